FILE: rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define SALC_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same, on the unit's own clock and reset names.
`define SALC_ASSERT(lbl, prop, msg) \
    `SALC_ASSERT_RST(lbl, aclk, aresetn, prop, msg)

`endif

FILE: rtl/salc_pkg.sv
package salc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_SETS_DEF   = 64;
    localparam int MAX_WAYS_DEF   = 8;
    localparam int ADDR_WIDTH_DEF = 48;

    // Fixed field widths
    localparam int KIND_W       = 2;
    localparam int ADDR_FIELD_W = 48;
    localparam int HITS_W       = 2;
    localparam int TOTAL_W      = 32;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    // Access kinds
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    // Register indexes (word address bits)
    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_WAYS_USED  = 2'd1;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

    // Outcome of one set lookup
    typedef struct packed {
        logic hit;
        logic evict;
    } lkp_status_t;

endpackage

FILE: rtl/set_assoc_lru_cache_model_unit.sv
// Channel | Ports                               | Moves
// --------+-------------------------------------+-----------------------------------
// s_      | s_valid s_ready s_kind s_address    | one access per transfer
// m_      | m_valid m_ready m_hits ... totals   | one result per access
// APB     | psel penable pwrite paddr pwdata .. | set_bits 0x0, ways_used 0x4,
//         |                                     | block_bits 0x8
//
// An access reads its set row from the set memory in the accept cycle and writes it
// back as the result register takes its result; the set memory port sets the pace.
// After reset a clearing pass writes every set row, with s_ready low;
// configuration writes are taken meanwhile.
// The result waits in an output register; a stall there holds the access
// in its lookup cycle until the result slot frees.
module set_assoc_lru_cache_model_unit import salc_pkg::*; #(
    parameter int MAX_SETS   = MAX_SETS_DEF,
    parameter int MAX_WAYS   = MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // access channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KIND_W-1:0]     s_kind,
    input  logic [ADDR_WIDTH-1:0] s_address,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [HITS_W-1:0]     m_hits,
    output logic                  m_missed,
    output logic                  m_evicted,
    output logic [TOTAL_W-1:0]    m_total_hits,
    output logic [TOTAL_W-1:0]    m_total_misses,
    output logic [TOTAL_W-1:0]    m_total_evictions,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SET_LIM = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ENT_W   = 1 + WAY_W + ADDR_WIDTH;
    localparam int ROW_W   = MAX_WAYS * ENT_W;
    localparam int AW_EFF  = (ADDR_WIDTH < ADDR_FIELD_W) ? ADDR_WIDTH : ADDR_FIELD_W;
    localparam logic [ADDR_WIDTH-1:0] AMASK = {ADDR_WIDTH{1'b1}} >> (ADDR_WIDTH - AW_EFF);

    // configuration registers
    logic [2:0] set_bits_reg;
    logic [3:0] ways_used_reg;
    logic [5:0] block_bits_reg;

    // control
    logic             clr_reg;
    logic [SET_W-1:0] clr_idx_reg;
    logic             busy_reg;
    logic [SET_W-1:0] idx_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic [KIND_W-1:0]     kind_reg;

    // result
    logic              m_valid_reg;
    logic [HITS_W-1:0] hits_reg;
    logic              missed_reg;
    logic              evicted_reg;
    logic [TOTAL_W-1:0] hit_total_reg;
    logic [TOTAL_W-1:0] miss_total_reg;
    logic [TOTAL_W-1:0] evict_total_reg;

    logic [HITS_W-1:0] hits_next;
    logic              missed_next;
    logic              evicted_next;

    logic                  accept;
    logic                  done;
    logic                  kind_ok;
    logic [ADDR_WIDTH-1:0] addr_m;
    logic [ADDR_WIDTH-1:0] above;
    logic [2:0]            sb_eff;
    logic [6:0]            tag_shift;
    logic [SET_W-1:0]      idx;
    logic [ADDR_WIDTH-1:0] tag;
    logic [MAX_WAYS-1:0]   in_use;

    logic             ram_wr_en;
    logic [SET_W-1:0] ram_wr_addr;
    logic [ROW_W-1:0] ram_wr_data;
    logic [ROW_W-1:0] row_rd;
    logic [ROW_W-1:0] row_wr;
    lkp_status_t      lkp_status;

    // APB: always ready, registers at word addresses
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg   <= 3'd0;
            ways_used_reg  <= 4'd1;
            block_bits_reg <= 6'd0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_SET_BITS:   set_bits_reg   <= pwdata[2:0];
                REG_WAYS_USED:  ways_used_reg  <= pwdata[3:0];
                REG_BLOCK_BITS: block_bits_reg <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SET_BITS:   prdata = {{(PDATA_W-3){1'b0}}, set_bits_reg};
            REG_WAYS_USED:  prdata = {{(PDATA_W-4){1'b0}}, ways_used_reg};
            REG_BLOCK_BITS: prdata = {{(PDATA_W-6){1'b0}}, block_bits_reg};
            default:        prdata = '0;
        endcase
    end

    // Address split: set count clamped to the memory, huge shifts give zero
    assign addr_m    = s_address & AMASK;
    assign sb_eff    = (32'(set_bits_reg) > SET_LIM) ? 3'(SET_LIM) : set_bits_reg;
    assign above     = addr_m >> block_bits_reg;
    assign idx       = above[SET_W-1:0] & ~({SET_W{1'b1}} << sb_eff);
    assign tag_shift = {1'b0, block_bits_reg} + {4'd0, sb_eff};
    assign tag       = addr_m >> tag_shift;

    // Ways in use; zero ways counts as one
    always_comb begin
        for (int j = 0; j < MAX_WAYS; j++) begin
            in_use[j] = (ways_used_reg == 4'd0) ? (j == 0) : (32'(ways_used_reg) > 32'(j));
        end
    end

    // Handshake
    assign s_ready = !clr_reg && !busy_reg;
    assign accept  = s_valid && s_ready;
    assign done    = busy_reg && (!m_valid_reg || m_ready);
    assign kind_ok = (kind_reg != KIND_NONE);

    // Access control and clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
            busy_reg    <= 1'b0;
        end else begin
            if (clr_reg) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == SET_W'(MAX_SETS - 1)) begin
                    clr_reg <= 1'b0;
                end
            end
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg  <= idx;
            tag_reg  <= tag;
            kind_reg <= s_kind;
        end
    end

    // Set memory: one row of ways per set
    assign ram_wr_en   = clr_reg || (done && kind_ok);
    assign ram_wr_addr = clr_reg ? clr_idx_reg : idx_reg;
    assign ram_wr_data = clr_reg ? '0 : row_wr;

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_set_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (idx),
        .rd_data (row_rd)
    );

    salc_lookup #(
        .MAX_WAYS (MAX_WAYS),
        .TAG_W    (ADDR_WIDTH)
    ) u_lookup (
        .row_rd (row_rd),
        .tag    (tag_reg),
        .in_use (in_use),
        .row_wr (row_wr),
        .status (lkp_status)
    );

    // Per-access counts; the store half of a modify always hits
    always_comb begin
        hits_next    = '0;
        missed_next  = 1'b0;
        evicted_next = 1'b0;
        if (kind_ok) begin
            hits_next    = HITS_W'({1'b0, lkp_status.hit} + (kind_reg == KIND_MODIFY));
            missed_next  = !lkp_status.hit;
            evicted_next = lkp_status.evict;
        end
    end

    // Result register and saturating totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
        end else begin
            if (done) begin
                m_valid_reg     <= 1'b1;
                hit_total_reg   <= sat_add(hit_total_reg, hits_next);
                miss_total_reg  <= sat_add(miss_total_reg, {1'b0, missed_next});
                evict_total_reg <= sat_add(evict_total_reg, {1'b0, evicted_next});
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            hits_reg    <= hits_next;
            missed_reg  <= missed_next;
            evicted_reg <= evicted_next;
        end
    end

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [HITS_W-1:0]  b);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, a} + {{(TOTAL_W+1-HITS_W){1'b0}}, b};
        return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
    endfunction

    assign m_valid           = m_valid_reg;
    assign m_hits            = hits_reg;
    assign m_missed          = missed_reg;
    assign m_evicted         = evicted_reg;
    assign m_total_hits      = hit_total_reg;
    assign m_total_misses    = miss_total_reg;
    assign m_total_evictions = evict_total_reg;

endmodule

FILE: rtl/salc_ram.sv
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/salc_lookup.sv
module salc_lookup import salc_pkg::*; #(
    parameter int MAX_WAYS = MAX_WAYS_DEF,
    parameter int TAG_W    = ADDR_WIDTH_DEF
) (
    input  logic [MAX_WAYS*(1+(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)+TAG_W)-1:0] row_rd,
    input  logic [TAG_W-1:0]    tag,
    input  logic [MAX_WAYS-1:0] in_use,
    output logic [MAX_WAYS*(1+(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)+TAG_W)-1:0] row_wr,
    output lkp_status_t         status
);

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W = WAY_W;
    localparam int ENT_W = 1 + AGE_W + TAG_W;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

    logic             ent_v   [MAX_WAYS];
    logic [AGE_W-1:0] ent_age [MAX_WAYS];
    logic [TAG_W-1:0] ent_tag [MAX_WAYS];
    logic [MAX_WAYS-1:0] match;

    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic [AGE_W-1:0] hit_age;
    logic             has_empty;
    logic [WAY_W-1:0] empty_way;
    logic             has_vic;
    logic [WAY_W-1:0] vic_way;
    logic [AGE_W-1:0] vic_age;
    logic [WAY_W-1:0] use_way;
    logic [AGE_W-1:0] old_age;

    // Unpack the set row and compare tags in parallel
    always_comb begin
        for (int j = 0; j < MAX_WAYS; j++) begin
            ent_tag[j] = row_rd[j*ENT_W +: TAG_W];
            ent_age[j] = row_rd[j*ENT_W + TAG_W +: AGE_W];
            ent_v[j]   = row_rd[j*ENT_W + TAG_W + AGE_W];
            match[j]   = in_use[j] && ent_v[j] && (ent_tag[j] == tag);
        end
    end

    // Hit way (lowest), fill way (highest invalid), victim (oldest, lowest on a tie)
    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        hit_age   = '0;
        has_empty = 1'b0;
        empty_way = '0;
        has_vic   = 1'b0;
        vic_way   = '0;
        vic_age   = '0;
        for (int j = MAX_WAYS - 1; j >= 0; j--) begin
            if (match[j]) begin
                hit     = 1'b1;
                hit_way = WAY_W'(j);
                hit_age = ent_age[j];
            end
        end
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (in_use[j] && !ent_v[j]) begin
                has_empty = 1'b1;
                empty_way = WAY_W'(j);
            end else if (in_use[j] && (!has_vic || ent_age[j] > vic_age)) begin
                has_vic = 1'b1;
                vic_way = WAY_W'(j);
                vic_age = ent_age[j];
            end
        end
        if (hit) begin
            use_way = hit_way;
            old_age = hit_age;
        end else if (has_empty) begin
            use_way = empty_way;
            old_age = AGE_MAX;
        end else begin
            use_way = vic_way;
            old_age = vic_age;
        end
    end

    // Rebuild the row: used way becomes newest, younger valid ways age by one
    always_comb begin
        row_wr = row_rd;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (WAY_W'(j) == use_way) begin
                row_wr[j*ENT_W +: ENT_W] = {1'b1, {AGE_W{1'b0}}, tag};
            end else if (in_use[j] && ent_v[j] && ent_age[j] < old_age) begin
                row_wr[j*ENT_W + TAG_W +: AGE_W] = AGE_W'(ent_age[j] + 1'b1);
            end
        end
    end

    assign status.hit   = hit;
    assign status.evict = !hit && !has_empty;

endmodule

FILE: rtl/salc_checker.sv
`include "assert_macros.svh"

module salc_checker import salc_pkg::*; #(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [KIND_W-1:0]     s_kind,
    input logic [ADDR_WIDTH-1:0] s_address,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [HITS_W-1:0]     m_hits,
    input logic                  m_missed,
    input logic                  m_evicted,
    input logic [TOTAL_W-1:0]    m_total_hits,
    input logic [TOTAL_W-1:0]    m_total_misses,
    input logic [TOTAL_W-1:0]    m_total_evictions,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [PADDR_W-1:0]    paddr,
    input logic [PDATA_W-1:0]    pwdata,
    input logic [PDATA_W-1:0]    prdata,
    input logic                  pready
);

    // A stalled result keeps its counts
    `SALC_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_hits) && $stable(m_missed) && $stable(m_evicted), "result changed under stall")

    // Only a miss can evict; a double hit never comes with a miss
    `SALC_ASSERT(a_result_legal, m_valid |-> !(m_evicted && !m_missed) && (m_hits != 2'd3) && !(m_hits == 2'd2 && m_missed), "impossible result combination")

    // One access at a time: no new transfer in the lookup cycle
    `SALC_ASSERT(a_one_in_flight, s_valid && s_ready |=> !s_ready, "access accepted during lookup")

    // Running totals never fall outside reset
    `SALC_ASSERT(a_totals_rise, aresetn |=> m_total_hits >= $past(m_total_hits) && m_total_misses >= $past(m_total_misses) && m_total_evictions >= $past(m_total_evictions), "running total decreased")

endmodule

bind set_assoc_lru_cache_model_unit salc_checker #(.ADDR_WIDTH(ADDR_WIDTH)) u_salc_checker (.*);
